// File: rtl/core/ihex_pkg.sv
// Shared types, constants and helpers for the Intel HEX record parser.
`default_nettype none

package ihex_pkg;

  // Character position counter saturates here; pair decoding stops.
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = 9'd511;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] NIBBLE_BAD = 8'hFF;

  // Record framing: length below which a line is short, and fixed overhead in characters.
  localparam logic [POS_W-1:0] MIN_LINE_CHARS = 9'd10;
  localparam logic [9:0]       LINE_OVERHEAD  = 10'd11;

  // Record types.
  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;

  // Header pair slots, counted from the byte count pair.
  localparam logic [7:0] PAIR_COUNT   = 8'd1;
  localparam logic [7:0] PAIR_ADDR_HI = 8'd2;
  localparam logic [7:0] PAIR_ADDR_LO = 8'd3;
  localparam logic [7:0] PAIR_TYPE    = 8'd4;
  localparam logic [7:0] PAIR_PAYLOAD = 8'd5;

  localparam int unsigned BADDR_W = 17;

  // Line status codes.
  localparam logic [3:0] ST_DATA_OK    = 4'd0;
  localparam logic [3:0] ST_EOF        = 4'd1;
  localparam logic [3:0] ST_UNKNOWN    = 4'd2;
  localparam logic [3:0] ST_BEYOND_EOF = 4'd3;
  localparam logic [3:0] ST_SHORT      = 4'd4;
  localparam logic [3:0] ST_NO_COLON   = 4'd5;
  localparam logic [3:0] ST_LENGTH     = 4'd6;
  localparam logic [3:0] ST_CHECKSUM   = 4'd7;
  localparam logic [3:0] ST_TOO_LONG   = 4'd8;

  // Result kinds on the output tuser.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_char;    // decode one accepted character
    logic eval;         // evaluate the finished line
    logic rd_en;        // read the payload buffer at the current index
    logic load_byte;    // place a data byte transaction in the output register
    logic load_status;  // place the line status transaction and clear the line
  } ihex_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_data;    // line is a valid data record with payload
    logic out_free;     // output register can take a transaction this cycle
    logic idx_last;     // current index is the last payload byte
  } ihex_stat_t;

  // Hex digit value; anything else decodes as 0xFF.
  function automatic logic [7:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = NIBBLE_BAD;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ihex_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ihex_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port, read port with held output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ihex_ctrl.sv
// Controller state machine of the Intel HEX record parser.
`default_nettype none

module ihex_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tlast,
  output logic                    in_tready,
  input  wire ihex_pkg::ihex_stat_t stat,
  output ihex_pkg::ihex_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_RUN,   // take characters
    S_RD,    // read one payload byte
    S_LOAD,  // hand the byte to the output register
    S_STAT   // hand the line status to the output register
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_acc;

  assign in_tready = (state_r == S_RUN);
  assign in_acc    = in_tvalid && in_tready;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_RUN: begin
        if (in_acc && !in_tlast) begin
          cmd.take_char = 1'b1;
        end
        if (in_acc && in_tlast) begin
          cmd.eval  = 1'b1;
          state_nxt = stat.emit_data ? S_RD : S_STAT;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          state_nxt     = stat.idx_last ? S_STAT : S_RD;
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.load_status = 1'b1;
          state_nxt       = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A byte is handed over only after its buffer read
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_byte |-> state_r == S_LOAD && $past(state_r) != S_RUN)
    else $error("byte load without a preceding buffer read");

  // Evaluation leaves the run state at once
  a_eval_leaves_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |=> state_r == S_RD || state_r == S_STAT)
    else $error("line evaluation did not start result delivery");

endmodule

`default_nettype wire

// File: rtl/core/ihex_dp.sv
// Datapath of the Intel HEX record parser: decode, checks, buffer and output register.
`default_nettype none

module ihex_dp #(
  parameter int MAX_RECORD_BYTES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           in_tdata,
  input  wire ihex_pkg::ihex_cmd_t  cmd,
  output ihex_pkg::ihex_stat_t      stat,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,
  output logic                      out_tuser,
  output logic                      out_tlast
);

  localparam int BUF_AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
  localparam int IDX_W  = $clog2(MAX_RECORD_BYTES + 1);
  localparam logic [7:0] MAX_BYTES = 8'(MAX_RECORD_BYTES);

  // Per-line state
  logic [ihex_pkg::POS_W-1:0] pos_r;
  logic [3:0]                 hi_r;
  logic [7:0]                 count_r;
  logic [15:0]                addr_r;
  logic [7:0]                 type_r;
  logic [7:0]                 sum_r;
  logic                       fault_r;
  // Persistent state
  logic                       eof_r;
  logic                       seg_open_r;
  logic [ihex_pkg::BADDR_W-1:0] next_addr_r;
  // Delivery
  logic [IDX_W-1:0]           idx_r;
  logic [3:0]                 status_r;
  logic                       fresh_r;
  logic                       out_valid_r;
  logic                       out_kind_r;
  logic [3:0]                 out_status_r;
  logic [7:0]                 out_byte_r;
  logic [ihex_pkg::BADDR_W-1:0] out_baddr_r;
  logic                       out_seg_r;
  logic                       out_last_r;

  logic [7:0]  lo;
  logic [7:0]  pair;
  logic [7:0]  pair_idx;
  logic [7:0]  buf_off;
  logic        char_live;
  logic        buf_we;
  logic [7:0]  buf_rdata;
  logic [9:0]  len_need;
  logic [3:0]  line_status;
  logic        line_fresh;
  logic [ihex_pkg::BADDR_W-1:0] rec_addr;

  // Decode the current character as the low digit of a pair
  assign lo        = ihex_pkg::hex_nibble(in_tdata);
  assign pair      = {hi_r, 4'h0} + lo;
  assign pair_idx  = pos_r[ihex_pkg::POS_W-1:1];
  assign buf_off   = pair_idx - ihex_pkg::PAIR_PAYLOAD;
  assign char_live = cmd.take_char && (pos_r != ihex_pkg::POS_MAX);
  assign buf_we    = char_live && (pos_r != '0) && !pos_r[0] &&
                     (pair_idx >= ihex_pkg::PAIR_PAYLOAD) && (buf_off < MAX_BYTES);

  ihex_ram #(
    .DATA_W (8),
    .DEPTH  (MAX_RECORD_BYTES),
    .ADDR_W (BUF_AW)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_off[BUF_AW-1:0]),
    .wdata (pair),
    .re    (cmd.rd_en),
    .raddr (idx_r[BUF_AW-1:0]),
    .rdata (buf_rdata)
  );

  // Check the finished line in priority order
  assign len_need = ihex_pkg::LINE_OVERHEAD + {1'b0, count_r, 1'b0};
  assign rec_addr = ihex_pkg::BADDR_W'(addr_r);

  always_comb begin
    if (eof_r) begin
      line_status = ihex_pkg::ST_BEYOND_EOF;
    end else if (pos_r < ihex_pkg::MIN_LINE_CHARS) begin
      line_status = ihex_pkg::ST_SHORT;
    end else if (fault_r) begin
      line_status = ihex_pkg::ST_NO_COLON;
    end else if (count_r > MAX_BYTES) begin
      line_status = ihex_pkg::ST_TOO_LONG;
    end else if (10'(pos_r) != len_need) begin
      line_status = ihex_pkg::ST_LENGTH;
    end else if (sum_r != 8'h00) begin
      line_status = ihex_pkg::ST_CHECKSUM;
    end else if (type_r == ihex_pkg::TYPE_DATA) begin
      line_status = ihex_pkg::ST_DATA_OK;
    end else if (type_r == ihex_pkg::TYPE_EOF) begin
      line_status = ihex_pkg::ST_EOF;
    end else begin
      line_status = ihex_pkg::ST_UNKNOWN;
    end
  end

  assign line_fresh = !seg_open_r || (rec_addr != next_addr_r);

  assign stat.emit_data = (line_status == ihex_pkg::ST_DATA_OK) && (count_r != 8'h00);
  assign stat.out_free  = !out_valid_r || out_tready;
  assign stat.idx_last  = ((8'(idx_r) + 8'd1) == count_r);

  // Control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hi_r        <= '0;
      count_r     <= '0;
      addr_r      <= '0;
      type_r      <= '0;
      sum_r       <= '0;
      fault_r     <= 1'b0;
      eof_r       <= 1'b0;
      seg_open_r  <= 1'b0;
      next_addr_r <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Advance through the line one character at a time
      if (char_live) begin
        pos_r <= pos_r + 1'b1;
        if (pos_r == '0) begin
          fault_r <= (in_tdata != ihex_pkg::CHAR_COLON);
        end else if (pos_r[0]) begin
          hi_r <= lo[3:0];
        end else begin
          sum_r <= sum_r + pair;
          if (pair_idx == ihex_pkg::PAIR_COUNT) begin
            count_r <= pair;
          end else if (pair_idx == ihex_pkg::PAIR_ADDR_HI) begin
            addr_r <= {pair, 8'h00};
          end else if (pair_idx == ihex_pkg::PAIR_ADDR_LO) begin
            addr_r <= addr_r + 16'(pair);
          end else if (pair_idx == ihex_pkg::PAIR_TYPE) begin
            type_r <= pair;
          end
        end
      end
      // Commit record effects at end of line
      if (cmd.eval) begin
        idx_r <= '0;
        if (line_status == ihex_pkg::ST_DATA_OK) begin
          seg_open_r  <= 1'b1;
          next_addr_r <= rec_addr + ihex_pkg::BADDR_W'(count_r);
        end
        if (line_status == ihex_pkg::ST_EOF) begin
          eof_r <= 1'b1;
        end
      end
      if (cmd.load_byte) begin
        idx_r <= idx_r + 1'b1;
      end
      // Drop per-line state once the status goes out
      if (cmd.load_status) begin
        pos_r   <= '0;
        hi_r    <= '0;
        count_r <= '0;
        addr_r  <= '0;
        type_r  <= '0;
        sum_r   <= '0;
        fault_r <= 1'b0;
      end
      out_valid_r <= cmd.load_byte || cmd.load_status || (out_valid_r && !out_tready);
    end
  end

  // Latch line verdict and fill the output register
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status_r <= line_status;
      fresh_r  <= line_fresh;
    end
    if (cmd.load_byte) begin
      out_kind_r   <= ihex_pkg::KIND_DATA;
      out_status_r <= ihex_pkg::ST_DATA_OK;
      out_byte_r   <= buf_rdata;
      out_baddr_r  <= rec_addr + ihex_pkg::BADDR_W'(idx_r);
      out_seg_r    <= fresh_r && (idx_r == '0);
      out_last_r   <= 1'b0;
    end else if (cmd.load_status) begin
      out_kind_r   <= ihex_pkg::KIND_STATUS;
      out_status_r <= status_r;
      out_byte_r   <= 8'h00;
      out_baddr_r  <= '0;
      out_seg_r    <= 1'b0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_seg_r, out_baddr_r, out_byte_r, out_status_r};

  // Never overwrite a transaction that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_byte || cmd.load_status) |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // At most one datapath action per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take_char, cmd.eval, cmd.load_byte, cmd.load_status}))
    else $error("conflicting datapath commands");

  // Bytes are only read within the record's payload
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (8'(idx_r) < count_r) && (count_r <= MAX_BYTES))
    else $error("payload read beyond record length");

  // End of file is sticky until reset
  a_eof_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    eof_r |=> eof_r)
    else $error("end-of-file flag lost");

endmodule

`default_nettype wire

// File: rtl/core/intel_hex_record_parser.sv
// Intel HEX record parser top level: one character per transaction, results per line.
// Timing: a character yields no result; for a line that sends no data, the line-end marker
//   moves the controller to S_STAT; the status loads once the output register is free.
// Throughput: characters at one per cycle while in S_RUN; a valid data record sends its n
//   buffered bytes, each by a buffer read then an output load, then the status, and the next
//   character is taken after the status loads (n = 0 for other lines).
// Reset (rst_n low, synchronous): clears line state, end-of-file and segment tracking;
//   the payload buffer is not cleared.
`default_nettype none

module intel_hex_record_parser #(
  parameter int MAX_RECORD_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tlast,   // line_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [3:0] status, [11:4] data_byte,
                                       // [28:12] byte_address, [29] new_segment, [31:30] 0
  output logic             out_tuser,  // kind
  output logic             out_tlast   // last
);

  ihex_pkg::ihex_cmd_t  cmd;
  ihex_pkg::ihex_stat_t stat;

  ihex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ihex_dp #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
